// ===== src/y2i_pkg.sv =====
// ----------------------------------------------------------------------------
// YUYV to I420 converter package
// Shared constants, register indexes and beat types of the converter.
// ----------------------------------------------------------------------------
package y2i_pkg;

  localparam int CFG_W     = 12;
  localparam int REG_IDX_W = 1;
  localparam int OFFSET_W  = 22;
  localparam int SAMPLE_W  = 8;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  typedef enum logic [1:0] {
    PH_Y0,
    PH_Y1,
    PH_U,
    PH_V
  } phase_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] luma_first;
    logic [SAMPLE_W-1:0] chroma_blue;
    logic [SAMPLE_W-1:0] luma_second;
    logic [SAMPLE_W-1:0] chroma_red;
  } pixel_pair_t;

  typedef struct packed {
    logic [1:0]          plane;
    logic [OFFSET_W-1:0] offset;
    logic [SAMPLE_W-1:0] sample;
    logic                last_of_run;
  } write_beat_t;

endpackage

// ===== src/y2i_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module y2i_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/y2i_fifo.sv =====
// ----------------------------------------------------------------------------
// Small register FIFO
// Register-based queue used between the converter stages and at the output.
// ----------------------------------------------------------------------------
module y2i_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== src/y2i_front.sv =====
// ----------------------------------------------------------------------------
// Converter front end
// Accepts pixel pairs, tracks the raster position and computes plane bases.
// ----------------------------------------------------------------------------
module y2i_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int WW  = $clog2(MAX_WIDTH + 1),
  localparam int PW  = $clog2(MAX_WIDTH / 2 + 1),
  localparam int HW  = $clog2(MAX_HEIGHT + 1),
  localparam int CLW = $clog2(MAX_WIDTH / 2),
  localparam int QW  = 2 * y2i_pkg::OFFSET_W + CLW + 1 + $bits(y2i_pkg::pixel_pair_t)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  y2i_pkg::pixel_pair_t item,
  input  logic [WW-1:0]        frame_w,
  input  logic [PW-1:0]        pairs,
  input  logic [HW-1:0]        frame_h,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [QW-1:0]        q_data
);

  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int OW = y2i_pkg::OFFSET_W;

  typedef struct packed {
    logic [OW-1:0]        luma_base;
    logic [OW-1:0]        chroma_base;
    logic [CLW-1:0]       column;
    logic                 odd_row;
    y2i_pkg::pixel_pair_t pixels;
  } job_t;

  logic [CLW-1:0]       pair_column;
  logic [CLW-1:0]       pair_column_next;
  logic [RW-1:0]        row_index;
  logic [RW-1:0]        row_index_next;
  logic                 s1_valid;
  logic [CLW-1:0]       s1_col;
  logic [RW-1:0]        s1_row;
  y2i_pkg::pixel_pair_t s1_pixels;
  logic                 accept;
  logic                 s1_adv;
  logic                 col_wrap_in;
  logic [CLW-1:0]       col_cur;
  logic [RW-1:0]        row_cur;
  logic [HW-1:0]        row_step;
  logic [PW-1:0]        col_inc;
  logic [HW-1:0]        row_inc;
  logic [RW+WW-1:0]     luma_prod;
  logic [RW+PW-1:0]     chroma_prod;
  job_t                 job;

  assign s1_adv = s1_valid & ~q_full;
  assign full   = s1_valid & q_full;
  assign accept = push & ~full;

  // A column or row left out of range by a size change wraps before use.
  always_comb begin
    col_wrap_in = (PW'(pair_column) >= pairs);
    col_cur     = col_wrap_in ? '0 : pair_column;
    row_step    = HW'(row_index) + HW'(col_wrap_in);
    row_cur     = (row_step >= frame_h) ? '0 : RW'(row_step);
    col_inc     = PW'(col_cur) + PW'(1);
    row_inc     = HW'(row_cur) + HW'(1);
    if (col_inc >= pairs) begin
      pair_column_next = '0;
      row_index_next   = (row_inc >= frame_h) ? '0 : RW'(row_inc);
    end else begin
      pair_column_next = CLW'(col_inc);
      row_index_next   = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_column <= '0;
      row_index   <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (accept) begin
        pair_column <= pair_column_next;
        row_index   <= row_index_next;
      end
      s1_valid <= accept | (s1_valid & ~s1_adv);
    end
    if (accept) begin
      s1_col    <= col_cur;
      s1_row    <= row_cur;
      s1_pixels <= item;
    end
  end

  always_comb begin
    luma_prod        = (RW+WW)'(s1_row) * (RW+WW)'(frame_w);
    chroma_prod      = (RW+PW)'(s1_row >> 1) * (RW+PW)'(pairs);
    job.luma_base    = OW'(luma_prod);
    job.chroma_base  = OW'(chroma_prod);
    job.column       = s1_col;
    job.odd_row      = s1_row[0];
    job.pixels       = s1_pixels;
  end

  assign q_push = s1_adv;
  assign q_data = job;

endmodule

// ===== src/y2i_back.sv =====
// ----------------------------------------------------------------------------
// Converter back end
// Keeps the chroma line, averages chroma on odd rows and emits write beats.
// ----------------------------------------------------------------------------
module y2i_back #(
  parameter int MAX_WIDTH = 2048,
  localparam int CLW = $clog2(MAX_WIDTH / 2),
  localparam int QW  = 2 * y2i_pkg::OFFSET_W + CLW + 1 + $bits(y2i_pkg::pixel_pair_t)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic [QW-1:0]        q_data,
  input  logic                 o_full,
  output logic                 o_push,
  output y2i_pkg::write_beat_t o_data
);

  localparam int OW         = y2i_pkg::OFFSET_W;
  localparam int SW         = y2i_pkg::SAMPLE_W;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;

  typedef struct packed {
    logic [OW-1:0]        luma_base;
    logic [OW-1:0]        chroma_base;
    logic [CLW-1:0]       column;
    logic                 odd_row;
    y2i_pkg::pixel_pair_t pixels;
  } job_t;

  job_t                 job_in;
  y2i_pkg::phase_t      phase;
  y2i_pkg::phase_t      phase_next;
  logic                 busy;
  logic                 busy_next;
  logic                 odd_row;
  logic [OW-1:0]        luma_off;
  logic [OW-1:0]        chroma_off;
  y2i_pkg::pixel_pair_t pixels;
  logic [2*SW-1:0]      line_rd;
  logic                 last;
  logic                 load;
  logic [SW:0]          u_sum;
  logic [SW:0]          v_sum;

  assign job_in = q_data;
  assign last   = ((phase == y2i_pkg::PH_Y1) & ~odd_row) | (phase == y2i_pkg::PH_V);
  assign o_push = busy & ~o_full;
  assign load   = ~q_empty & (~busy | (o_push & last));
  assign q_pop  = load;

  y2i_ram #(
    .WIDTH (2 * SW),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (load & ~job_in.odd_row),
    .wr_addr (job_in.column),
    .wr_data ({job_in.pixels.chroma_red, job_in.pixels.chroma_blue}),
    .rd_en   (load & job_in.odd_row),
    .rd_addr (job_in.column),
    .rd_data (line_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= y2i_pkg::PH_Y0;
    end else begin
      busy  <= busy_next;
      phase <= phase_next;
    end
    if (load) begin
      odd_row    <= job_in.odd_row;
      luma_off   <= job_in.luma_base + OW'({job_in.column, 1'b0});
      chroma_off <= job_in.chroma_base + OW'(job_in.column);
      pixels     <= job_in.pixels;
    end
  end

  always_comb begin
    busy_next  = busy;
    phase_next = phase;
    if (load) begin
      busy_next  = 1'b1;
      phase_next = y2i_pkg::PH_Y0;
    end else if (o_push) begin
      if (last) begin
        busy_next = 1'b0;
      end
      case (phase)
        y2i_pkg::PH_Y0: phase_next = y2i_pkg::PH_Y1;
        y2i_pkg::PH_Y1: phase_next = y2i_pkg::PH_U;
        y2i_pkg::PH_U:  phase_next = y2i_pkg::PH_V;
        default:        phase_next = y2i_pkg::PH_Y0;
      endcase
    end
  end

  always_comb begin
    u_sum              = {1'b0, line_rd[SW-1:0]} + {1'b0, pixels.chroma_blue};
    v_sum              = {1'b0, line_rd[2*SW-1:SW]} + {1'b0, pixels.chroma_red};
    o_data.plane       = y2i_pkg::PLANE_Y;
    o_data.offset      = luma_off;
    o_data.sample      = pixels.luma_first;
    o_data.last_of_run = 1'b0;
    case (phase)
      y2i_pkg::PH_Y0: begin
        o_data.offset = luma_off;
      end
      y2i_pkg::PH_Y1: begin
        o_data.offset      = {luma_off[OW-1:1], 1'b1};
        o_data.sample      = pixels.luma_second;
        o_data.last_of_run = ~odd_row;
      end
      y2i_pkg::PH_U: begin
        o_data.plane  = y2i_pkg::PLANE_U;
        o_data.offset = chroma_off;
        o_data.sample = u_sum[SW:1];
      end
      default: begin
        o_data.plane       = y2i_pkg::PLANE_V;
        o_data.offset      = chroma_off;
        o_data.sample      = v_sum[SW:1];
        o_data.last_of_run = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/yuyv422_to_i420_converter_core.sv =====
// ----------------------------------------------------------------------------
// YUYV 4:2:2 to I420 converter core
// The core takes packed YUYV pixel pairs in raster order and returns one
// write beat per planar byte, each naming the plane, the byte offset in that
// plane and the byte. An even-row pair gives two luma beats and stores its
// chroma in a line buffer; an odd-row pair gives two luma beats and the
// averaged U and V beats. The back end writes one beat per cycle into the
// output queue while it is not full; the front end takes a new pair every
// cycle until the four-entry work queue fills. Pairs pass the front-end
// register, work queue, back-end registers and output queue in turn. The
// user must write frame width and height through the configuration port
// only while the core is idle; the core does not enforce this. Odd values
// are rounded down; the size is held between two and the parameter maxima.
// ----------------------------------------------------------------------------
module yuyv422_to_i420_converter_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  y2i_pkg::pixel_pair_t                item,
  output logic                                empty,
  input  logic                                pop,
  output y2i_pkg::write_beat_t                result,
  input  logic                                cfg_we,
  input  logic [y2i_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [y2i_pkg::CFG_W-1:0]           cfg_data
);

  localparam int CW  = y2i_pkg::CFG_W;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int PW  = $clog2(MAX_WIDTH / 2 + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CLW = $clog2(MAX_WIDTH / 2);
  localparam int QW  = 2 * y2i_pkg::OFFSET_W + CLW + 1 + $bits(y2i_pkg::pixel_pair_t);
  localparam int BW  = $bits(y2i_pkg::write_beat_t);

  logic [CW-1:0] frame_width;
  logic [CW-1:0] frame_height;
  logic [CW-1:0] width_even;
  logic [CW-1:0] height_even;
  logic [WW-1:0] width_lim;
  logic [HW-1:0] height_lim;
  logic [PW-1:0] pairs;

  logic          q_push;
  logic [QW-1:0] q_wr_data;
  logic          q_full;
  logic          q_pop;
  logic [QW-1:0] q_rd_data;
  logic          q_empty;

  logic                 o_push;
  y2i_pkg::write_beat_t o_data;
  logic                 o_full;
  logic [BW-1:0]        o_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CW'(320);
      frame_height <= CW'(240);
    end else if (cfg_we) begin
      case (cfg_index)
        y2i_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        y2i_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign width_even  = {frame_width[CW-1:1], 1'b0};
  assign height_even = {frame_height[CW-1:1], 1'b0};

  always_comb begin
    if (width_even < CW'(2)) begin
      width_lim = WW'(2);
    end else if (int'(width_even) > MAX_WIDTH) begin
      width_lim = WW'(MAX_WIDTH);
    end else begin
      width_lim = WW'(width_even);
    end
    if (height_even < CW'(2)) begin
      height_lim = HW'(2);
    end else if (int'(height_even) > MAX_HEIGHT) begin
      height_lim = HW'(MAX_HEIGHT);
    end else begin
      height_lim = HW'(height_even);
    end
    pairs = PW'(width_lim >> 1);
  end

  y2i_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .frame_w (width_lim),
    .pairs   (pairs),
    .frame_h (height_lim),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  y2i_fifo #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_work_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  y2i_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_rd_data),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_data  (o_data)
  );

  y2i_fifo #(
    .WIDTH (BW),
    .DEPTH (4)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (o_push),
    .wr_data (o_data),
    .full    (o_full),
    .rd_en   (pop),
    .rd_data (o_rd_data),
    .empty   (empty)
  );

  assign result = o_rd_data;

endmodule

// ===== src/y2i_checker.sv =====
// ----------------------------------------------------------------------------
// Converter port checker
// Checks the ordering and framing of result beats seen at the core's ports.
// ----------------------------------------------------------------------------
module y2i_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 pop,
  input logic                 empty,
  input y2i_pkg::write_beat_t result
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("Result queue is not empty after reset.");

  a_held_beat: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("A waiting result beat changed before it was taken.");

  a_v_follows_u: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && result.plane == y2i_pkg::PLANE_U
      |=> !empty && result.plane == y2i_pkg::PLANE_V)
    else $error("A U beat was not followed by its V beat.");

  a_luma_last_odd: assert property (@(posedge clk) disable iff (rst)
    !empty && result.last_of_run && result.plane == y2i_pkg::PLANE_Y
      |-> result.offset[0])
    else $error("A run ended on a left luma pixel.");

  a_v_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty && result.plane == y2i_pkg::PLANE_V |-> result.last_of_run)
    else $error("A V beat did not end its run.");

endmodule

bind yuyv422_to_i420_converter_core y2i_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .pop    (pop),
  .empty  (empty),
  .result (result)
);
